// ===== sv/hbs_pkg.sv =====
// ---------------------------------------------------------------------------
// hbs_pkg
// Shared constants, codes and controller/datapath interface types for the
// height-field bilinear sampler.
// ---------------------------------------------------------------------------
package hbs_pkg;

	localparam int GRID_SIDE = 64;
	localparam int DEPTH     = GRID_SIDE * GRID_SIDE;
	localparam int ADDR_W    = $clog2(DEPTH);
	localparam int CELL_W    = $clog2(GRID_SIDE);

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	localparam logic REG_GRID_POINTS = 1'b0;
	localparam logic REG_HALF_EXTENT = 1'b1;

	typedef struct packed {
		logic wr;
		logic cap;
		logic calc;
		logic rd_sel;
		logic row_top;
		logic row_bot;
		logic col;
		logic fin;
	} hbs_cmd_t;

	typedef struct packed {
		logic oor;
	} hbs_stat_t;

endpackage

// ===== sv/hbs_ctrl.sv =====
// ---------------------------------------------------------------------------
// hbs_ctrl
// Sequencer for sample writes and height queries: steps the datapath through
// range check, two paired table reads, row and column blends, and output.
// ---------------------------------------------------------------------------
module hbs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              req_type,
	input  hbs_pkg::hbs_stat_t stat,
	output hbs_pkg::hbs_cmd_t  cmd,
	output logic              busy,
	output logic              done
);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_CALC = 7'b0000010,
		ST_RD0  = 7'b0000100,
		ST_RD1  = 7'b0001000,
		ST_ROW1 = 7'b0010000,
		ST_COL  = 7'b0100000,
		ST_FIN  = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   done_q;
	logic   accept;

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign accept = start && (state_q == ST_IDLE);

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.wr      = accept && (req_type == hbs_pkg::REQ_WRITE);
		cmd.cap     = accept && (req_type == hbs_pkg::REQ_QUERY);
		case (state_q)
			ST_IDLE: begin
				if (cmd.cap)
					state_d = ST_CALC;
			end
			ST_CALC: begin
				cmd.calc = 1'b1;
				state_d  = stat.oor ? ST_FIN : ST_RD0;
			end
			ST_RD0: begin
				state_d = ST_RD1;
			end
			ST_RD1: begin
				cmd.rd_sel  = 1'b1;
				cmd.row_top = 1'b1;
				state_d     = ST_ROW1;
			end
			ST_ROW1: begin
				cmd.row_bot = 1'b1;
				state_d     = ST_COL;
			end
			ST_COL: begin
				cmd.col = 1'b1;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				cmd.fin = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.fin;
		end
	end

endmodule

// ===== sv/hbs_dpath.sv =====
// ---------------------------------------------------------------------------
// hbs_dpath
// Configuration registers, height table with two read ports, cell and weight
// computation, row and column blends, rounding and result registers.
// ---------------------------------------------------------------------------
module hbs_dpath (
	input  logic                     clk,
	input  logic                     arst_n,
	input  hbs_pkg::hbs_cmd_t         cmd,
	output hbs_pkg::hbs_stat_t        stat,
	input  logic                     cfg_valid,
	input  logic                     cfg_index,
	input  logic [13:0]              cfg_data,
	input  logic [11:0]              entry_index,
	input  logic signed [23:0]       entry_height,
	input  logic signed [23:0]       pos_x,
	input  logic signed [23:0]       pos_z,
	output logic signed [23:0]       height_out,
	output logic                     in_range
);

	logic [6:0]                      grid_points_q;
	logic [13:0]                     half_extent_q;
	logic signed [23:0]              pos_x_q, pos_z_q;
	logic [6:0]                      n_w;
	logic signed [24:0]              sx_w, sz_w;
	logic [14:0]                     ix_w, iz_w, lim_w;
	logic                            oor_w;
	logic [hbs_pkg::ADDR_W-1:0]      r0_w, r0_q;
	logic [7:0]                      tx_q, tz_q;
	logic                            oor_q;
	logic [hbs_pkg::ADDR_W-1:0]      addr_a, addr_b;
	logic [23:0]                     mem [hbs_pkg::DEPTH];
	logic [23:0]                     rd_a_q, rd_b_q;
	logic signed [24:0]              rdiff_w;
	logic signed [33:0]              rprod_w, row_w, top_q, bot_q;
	logic signed [34:0]              cdiff_w;
	logic signed [43:0]              cprod_w, col_w, v_q, vr_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_points_q <= '0;
			half_extent_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				hbs_pkg::REG_GRID_POINTS: grid_points_q <= cfg_data[6:0];
				hbs_pkg::REG_HALF_EXTENT: half_extent_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign n_w   = (grid_points_q > 7'(hbs_pkg::GRID_SIDE)) ?
	               7'(hbs_pkg::GRID_SIDE) : grid_points_q;
	assign sx_w  = $signed({pos_x_q[23], pos_x_q}) + $signed({11'd0, half_extent_q});
	assign sz_w  = $signed({pos_z_q[23], pos_z_q}) + $signed({11'd0, half_extent_q});
	assign ix_w  = sx_w[23:9];
	assign iz_w  = sz_w[23:9];
	assign lim_w = {8'd0, n_w - 7'd1};
	assign oor_w = (n_w <= 7'd1) || sx_w[24] || sz_w[24] || (ix_w >= lim_w) ||
	               (iz_w >= lim_w);
	assign r0_w  = 12'({6'd0, iz_w[hbs_pkg::CELL_W-1:0]} * {5'd0, n_w}) +
	               {6'd0, ix_w[hbs_pkg::CELL_W-1:0]};
	assign stat.oor = oor_w;

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			pos_x_q <= pos_x;
			pos_z_q <= pos_z;
		end
		if (cmd.calc) begin
			oor_q <= oor_w;
			r0_q  <= r0_w;
			tx_q  <= sx_w[8:1];
			tz_q  <= sz_w[8:1];
		end
	end

	assign addr_a = cmd.rd_sel ? (r0_q + {5'd0, n_w}) : r0_q;
	assign addr_b = addr_a + 12'd1;

	always_ff @(posedge clk) begin
		if (cmd.wr)
			mem[entry_index] <= entry_height;
		rd_a_q <= mem[addr_a];
		rd_b_q <= mem[addr_b];
	end

	assign rdiff_w = $signed({rd_b_q[23], rd_b_q}) - $signed({rd_a_q[23], rd_a_q});
	assign rprod_w = rdiff_w * $signed({1'b0, tx_q});
	assign row_w   = rprod_w + $signed({{2{rd_a_q[23]}}, rd_a_q, 8'd0});

	assign cdiff_w = $signed({bot_q[33], bot_q}) - $signed({top_q[33], top_q});
	assign cprod_w = cdiff_w * $signed({1'b0, tz_q});
	assign col_w   = cprod_w + $signed({{2{top_q[33]}}, top_q, 8'd0});
	assign vr_w    = v_q + 44'sd32768;

	always_ff @(posedge clk) begin
		if (cmd.row_top)
			top_q <= row_w;
		if (cmd.row_bot)
			bot_q <= row_w;
		if (cmd.col)
			v_q <= col_w;
		if (cmd.fin) begin
			height_out <= oor_q ? 24'sd0 : vr_w[39:16];
			in_range   <= !oor_q;
		end
	end

endmodule

// ===== sv/heightfield_bilinear_sampler.sv =====
// ---------------------------------------------------------------------------
// heightfield_bilinear_sampler
// Bilinear height lookup over a square grid of Q16.8 samples.
// ---------------------------------------------------------------------------
// A word is accepted when start is high and busy is low. req_type selects a
// sample write (entry_index, entry_height) or a height query (pos_x, pos_z).
// A write completes at its accept edge and gives no result; busy stays low,
// so writes can be issued every cycle.
// A query raises busy through range check and cell address, paired reads
// of the top and bottom rows from the two-port height table, top and bottom
// row blends, column blend, then result load. The result (height_out,
// in_range) is registered at the result load and is valid for exactly one
// cycle with done, and the next word can be accepted in that same cycle. A
// position off the grid skips the reads and returns in_range low.
// The receiver cannot stall; done is a single-cycle strobe.
// Configuration: cfg_ready is always high; index 0 is grid_points, index 1
// is half_extent. Write only while busy is low.
// Reset clears both registers and the controller; table contents are
// undefined until written.
// ---------------------------------------------------------------------------
module heightfield_bilinear_sampler (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               req_type,
	input  logic [11:0]        entry_index,
	input  logic signed [23:0] entry_height,
	input  logic signed [23:0] pos_x,
	input  logic signed [23:0] pos_z,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [13:0]        cfg_data,
	output logic               done,
	output logic signed [23:0] height_out,
	output logic               in_range
);

	hbs_pkg::hbs_cmd_t  cmd;
	hbs_pkg::hbs_stat_t stat;

	assign cfg_ready = 1'b1;

	hbs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.stat     (stat),
		.cmd      (cmd),
		.busy     (busy),
		.done     (done)
	);

	hbs_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.entry_index  (entry_index),
		.entry_height (entry_height),
		.pos_x        (pos_x),
		.pos_z        (pos_z),
		.height_out   (height_out),
		.in_range     (in_range)
	);

endmodule

// ===== dv/hbs_height_checker.sv =====
// ---------------------------------------------------------------------------
// hbs_height_checker
// Watches the sampler's word, configuration and result ports. Keeps its own
// copy of the sample table and both registers, predicts the blended height
// of every accepted query and compares each done strobe against the oldest
// prediction. Hands the mismatch count and the number of results still owed
// to the testbench top.
// ---------------------------------------------------------------------------
module hbs_height_checker
	import hbs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic               req_type,
	input  logic [11:0]        entry_index,
	input  logic signed [23:0] entry_height,
	input  logic signed [23:0] pos_x,
	input  logic signed [23:0] pos_z,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [13:0]        cfg_data,
	input  logic               done,
	input  logic signed [23:0] height_out,
	input  logic               in_range,
	output int                 errors,
	output int                 outstanding
);

	typedef struct {
		logic signed [23:0] height;
		logic               in_range;
	} height_result_t;

	logic signed [23:0] sample_mem [DEPTH];
	logic [6:0]         grid_pts;
	logic [13:0]        half_ext;
	height_result_t     expected_heights [$];

	function automatic height_result_t blend_height(input logic signed [23:0] px,
			input logic signed [23:0] pz);
		height_result_t res;
		int             n;
		int             ix;
		int             iz;
		int             tx;
		int             tz;
		int             r0;
		int             r1;
		longint         sx;
		longint         sz;
		longint         top;
		longint         bot;
		longint         v;
		res.height   = '0;
		res.in_range = 1'b0;
		n  = (grid_pts > GRID_SIDE) ? GRID_SIDE : int'(grid_pts);
		sx = longint'(px) + longint'(half_ext);
		sz = longint'(pz) + longint'(half_ext);
		if (n <= 1 || sx < 0 || sz < 0)
			return res;
		ix = int'(sx >>> 9);
		iz = int'(sz >>> 9);
		if (ix >= n - 1 || iz >= n - 1)
			return res;
		tx  = int'((sx >>> 1) & 255);
		tz  = int'((sz >>> 1) & 255);
		r0  = iz * n + ix;
		r1  = r0 + n;
		top = longint'(sample_mem[12'(r0)]) * (256 - tx) +
		      longint'(sample_mem[12'(r0 + 1)]) * tx;
		bot = longint'(sample_mem[12'(r1)]) * (256 - tx) +
		      longint'(sample_mem[12'(r1 + 1)]) * tx;
		v   = top * (256 - tz) + bot * tz;
		res.height   = 24'((v + 32768) >>> 16);
		res.in_range = 1'b1;
		return res;
	endfunction

	always @(posedge clk) begin
		height_result_t want;
		if (!arst_n) begin
			grid_pts    = '0;
			half_ext    = '0;
			errors      = 0;
			outstanding = 0;
			expected_heights.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_GRID_POINTS)
					grid_pts = cfg_data[6:0];
				else
					half_ext = cfg_data;
			end
			if (done) begin
				if (expected_heights.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none, actual height %h in_range %b",
						$time, height_out, in_range);
				end else begin
					want = expected_heights.pop_front();
					if (height_out !== want.height) begin
						errors++;
						$display("%0t: height_out expected %h actual %h",
							$time, want.height, height_out);
					end
					if (in_range !== want.in_range) begin
						errors++;
						$display("%0t: in_range expected %b actual %b",
							$time, want.in_range, in_range);
					end
				end
			end
			if (start && !busy) begin
				if (req_type == REQ_WRITE) begin
					if (entry_index < DEPTH)
						sample_mem[entry_index] = entry_height;
				end else begin
					expected_heights.insert(expected_heights.size(),
						blend_height(pos_x, pos_z));
				end
			end
			outstanding = expected_heights.size();
		end
	end

endmodule

// ===== dv/heightfield_bilinear_sampler_tb.sv =====
// ---------------------------------------------------------------------------
// heightfield_bilinear_sampler_tb
// Drives sample writes, height queries and register writes into the sampler
// with random gaps, beside a checker that predicts every result. Covers the
// disabled grid, positions on and off every edge, the oversized grid and the
// rounding of halves, then random phases of mostly in-grid queries.
// ---------------------------------------------------------------------------
module heightfield_bilinear_sampler_tb;
	import hbs_pkg::*;

	localparam int HEIGHT_MAX      = 8388607;
	localparam int HEIGHT_MIN      = -8388608;
	localparam int HALF_EXTENT_MAX = 15872;
	localparam int GRID_POINTS_MAX = 127;
	localparam int CELL_STEP       = 512;
	localparam int RANDOM_ITEMS    = 1250;
	localparam int PHASES          = 8;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               req_type;
	logic [11:0]        entry_index;
	logic signed [23:0] entry_height;
	logic signed [23:0] pos_x;
	logic signed [23:0] pos_z;
	logic               cfg_valid;
	logic               cfg_ready;
	logic               cfg_index;
	logic [13:0]        cfg_data;
	logic               done;
	logic signed [23:0] height_out;
	logic               in_range;
	int                 errors;
	int                 outstanding;

	bit                 written [DEPTH];
	int                 cur_points;
	int                 cur_half;
	bit                 no_gaps;

	heightfield_bilinear_sampler u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req_type    (req_type),
		.entry_index (entry_index),
		.entry_height(entry_height),
		.pos_x       (pos_x),
		.pos_z       (pos_z),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.done        (done),
		.height_out  (height_out),
		.in_range    (in_range)
	);

	hbs_height_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req_type    (req_type),
		.entry_index (entry_index),
		.entry_height(entry_height),
		.pos_x       (pos_x),
		.pos_z       (pos_z),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.done        (done),
		.height_out  (height_out),
		.in_range    (in_range),
		.errors      (errors),
		.outstanding (outstanding)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#8000000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic int eff_points();
		return (cur_points > GRID_SIDE) ? GRID_SIDE : cur_points;
	endfunction

	function automatic logic signed [23:0] pick_height();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return 24'(HEIGHT_MAX);
		else if (r < 20)
			return 24'(HEIGHT_MIN);
		else if (r < 25)
			return '0;
		return 24'($urandom);
	endfunction

	function automatic logic signed [23:0] grid_coord();
		return 24'($urandom_range(0, eff_points() - 2) * CELL_STEP
			+ $urandom_range(0, CELL_STEP - 1) - cur_half);
	endfunction

	function automatic logic signed [23:0] edge_coord();
		case ($urandom_range(0, 3))
			0: return 24'(-1 - cur_half);
			1: return 24'((eff_points() - 1) * CELL_STEP - cur_half);
			2: return 24'((eff_points() - 1) * CELL_STEP - 1 - cur_half);
			default: return 24'($urandom);
		endcase
	endfunction

	// hold the word until accepted, then idle for a random gap
	task automatic send_word(input logic rt, input logic [11:0] idx,
			input logic signed [23:0] h, input logic signed [23:0] px,
			input logic signed [23:0] pz);
		int r;
		int gap;
		req_type     <= rt;
		entry_index  <= idx;
		entry_height <= h;
		pos_x        <= px;
		pos_z        <= pz;
		start        <= 1'b1;
		do @(posedge clk); while (busy);
		@(negedge clk);
		if (rt == REQ_WRITE)
			written[idx] = 1'b1;
		gap = 0;
		if (!no_gaps) begin
			r = $urandom_range(0, 99);
			if (r < 55)
				gap = 0;
			else if (r < 85)
				gap = $urandom_range(1, 2);
			else if (r < 96)
				gap = $urandom_range(3, 6);
			else
				gap = $urandom_range(10, 40);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic send_write(input logic [11:0] idx, input logic signed [23:0] h);
		send_word(REQ_WRITE, idx, h, 24'($urandom), 24'($urandom));
	endtask

	task automatic send_query(input logic signed [23:0] px, input logic signed [23:0] pz);
		send_word(REQ_QUERY, 12'($urandom), 24'($urandom), px, pz);
	endtask

	task automatic settle();
		start <= 1'b0;
		while (outstanding != 0 || busy)
			@(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	task automatic write_reg(input logic ri, input logic [13:0] d);
		cfg_index <= ri;
		cfg_data  <= d;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// drain, program both registers, then load every sample the grid can read
	task automatic configure(input int n, input int he);
		int side;
		settle();
		if ($urandom_range(0, 1)) begin
			write_reg(REG_GRID_POINTS, 14'(n));
			write_reg(REG_HALF_EXTENT, 14'(he));
		end else begin
			write_reg(REG_HALF_EXTENT, 14'(he));
			write_reg(REG_GRID_POINTS, 14'(n));
		end
		cur_points = n;
		cur_half   = he;
		side       = eff_points();
		for (int i = 0; i < side * side; i++)
			if (!written[12'(i)])
				send_write(12'(i), pick_height());
	endtask

	task automatic random_item();
		int r;
		int side;
		r    = $urandom_range(0, 99);
		side = eff_points();
		if (r < 15) begin
			if ($urandom_range(0, 3) == 0 || side < 2)
				send_write(12'($urandom), pick_height());
			else
				send_write(12'($urandom_range(0, side * side - 1)), pick_height());
		end else if (r < 20 || side < 2) begin
			send_query(24'($urandom), 24'($urandom));
		end else if (r < 30) begin
			if ($urandom_range(0, 1))
				send_query(edge_coord(), grid_coord());
			else
				send_query(grid_coord(), edge_coord());
		end else begin
			send_query(grid_coord(), grid_coord());
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		start        = 1'b0;
		req_type     = REQ_WRITE;
		entry_index  = '0;
		entry_height = '0;
		pos_x        = '0;
		pos_z        = '0;
		cfg_valid    = 1'b0;
		cfg_index    = REG_GRID_POINTS;
		cfg_data     = '0;
		cur_points   = 0;
		cur_half     = 0;
		no_gaps      = 1'b0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_query(0, 0);
		configure(1, 0);
		send_query(0, 0);

		configure(2, 0);
		send_write(0, 24'(HEIGHT_MAX));
		send_write(1, 24'(HEIGHT_MIN));
		send_write(2, 24'(HEIGHT_MIN));
		send_write(3, 24'(HEIGHT_MAX));
		send_query(0, 0);
		send_query(511, 511);
		send_query(256, 0);
		send_query(0, 511);
		send_query(-1, 0);
		send_query(0, -1);
		send_query(24'(CELL_STEP), 0);
		send_query(0, 24'(CELL_STEP));
		send_query(24'(HEIGHT_MAX), 24'(HEIGHT_MAX));
		send_query(24'(HEIGHT_MIN), 24'(HEIGHT_MIN));
		send_write(0, 0);
		send_write(1, -1);
		send_write(2, 0);
		send_write(3, -1);
		send_query(256, 0);
		send_query(256, 256);

		configure(GRID_POINTS_MAX, HALF_EXTENT_MAX);
		send_query(24'(-HALF_EXTENT_MAX), 24'(-HALF_EXTENT_MAX));
		send_query(24'(62 * CELL_STEP + 511 - HALF_EXTENT_MAX),
			24'(62 * CELL_STEP + 511 - HALF_EXTENT_MAX));
		send_query(24'(63 * CELL_STEP - HALF_EXTENT_MAX), 0);
		send_query(24'(-HALF_EXTENT_MAX - 1), 0);

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: configure(GRID_SIDE, HALF_EXTENT_MAX);
				1: configure(2, 0);
				2: configure($urandom_range(0, 1), $urandom_range(0, HALF_EXTENT_MAX));
				3: configure($urandom_range(GRID_SIDE + 1, GRID_POINTS_MAX),
					$urandom_range(0, HALF_EXTENT_MAX));
				default: configure($urandom_range(2, GRID_SIDE),
					$urandom_range(0, HALF_EXTENT_MAX));
			endcase
			no_gaps = ($urandom_range(0, 3) == 0);
			repeat (RANDOM_ITEMS / PHASES) random_item();
		end

		settle();
		if (errors == 0 && outstanding == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
